// ===== sv/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms; compiled out with NO_ASSERTIONS.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond_a in a cycle implies cond_b in the same cycle
`define ASSERT_IMPLIES(label, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond_a) |-> (cond_b)) else $error("assertion failed");

// cond_a in a cycle implies cond_b in the next cycle
`define ASSERT_NEXT(label, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond_a) |=> (cond_b)) else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, cond_a, cond_b)
`define ASSERT_NEXT(label, cond_a, cond_b)

`endif

`endif

// ===== sv/tcci_pkg.sv =====
// ============================================================================
// tcci_pkg
// Widths, stage word types and arithmetic helpers of the circumcircle block.
// ============================================================================
package tcci_pkg;

    // field and datapath widths
    localparam int CW     = 32;              // coordinate
    localparam int RSQW   = 64;              // squared radius output
    localparam int DW     = CW + 1;          // coordinate difference
    localparam int SQW    = 2 * CW;          // square of a difference
    localparam int SW     = SQW + 1;         // sum of two squares
    localparam int KW     = 2 * DW + 1;      // cross product, signed
    localparam int KMW    = KW - 1;          // cross product magnitude
    localparam int LO_W   = DW;              // low split of a sum of squares
    localparam int HI_W   = SW - LO_W;       // high split
    localparam int LPW    = DW + LO_W + 1;   // low partial product
    localparam int HPW    = DW + HI_W + 1;   // high partial product
    localparam int NW     = 100;             // determinant numerator, signed
    localparam int NMW    = NW - 1;          // numerator magnitude
    localparam int N2W    = NW + 1;          // rounded dividend
    localparam int DENW   = KMW + 2;         // rounded divisor 4|K|
    localparam int QW     = 35;              // quotient bits before saturation
    localparam int RW     = DENW + QW;       // divider compare width
    localparam int SUMW   = QW + 2;          // center before saturation

    // stream words
    localparam int IN_W   = 8 * CW;
    localparam int OUT_DW = 136;
    localparam int OUT_UW = 1;
    localparam int OUT_PAD = OUT_DW - (2 * CW + RSQW + 1);

    localparam logic signed [CW-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CW-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic [CW-1:0]        THR_RESET = 32'd1;

    typedef struct packed {
        logic signed [CW-1:0] ax, ay, bx, by, cx, cy, px, py;
    } coords_t;

    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic [RSQW-1:0]      radius_sq;
        logic                 tri_valid;
        logic                 inside_res;
    } result_t;

    typedef struct packed {
        coords_t c;
        logic signed [DW-1:0] bxp, byp, cxp, cyp;
    } st1_t;

    typedef struct packed {
        coords_t c;
        logic signed [DW-1:0]   bxp, byp, cxp, cyp;
        logic signed [2*DW-1:0] k1, k2;
        logic [SQW-1:0]         bb, byy, cxx, cyy;
    } st2_t;

    typedef struct packed {
        coords_t c;
        logic signed [DW-1:0] bxp, byp, cxp, cyp;
        logic signed [KW-1:0] k;
        logic [SW-1:0]        sb, sc;
    } st3_t;

    typedef struct packed {
        coords_t c;
        logic                  ksign;
        logic [KMW-1:0]        kmag;
        logic signed [LPW-1:0] pyl, pbl, pxl, pcl;
        logic signed [HPW-1:0] pyh, pbh, pxh, pch;
    } st4_t;

    typedef struct packed {
        coords_t c;
        logic                 ksign;
        logic [KMW-1:0]       kmag;
        logic                 valid;
        logic signed [NW-1:0] tcy, tby, tbx, tcx;
    } st5_t;

    typedef struct packed {
        coords_t c;
        logic                 ksign;
        logic [KMW-1:0]       kmag;
        logic                 valid;
        logic signed [NW-1:0] nx, ny;
    } st6_t;

    typedef struct packed {
        coords_t c;
        logic           ksign;
        logic [KMW-1:0] kmag;
        logic           valid;
        logic           nxneg, nyneg;
        logic [NMW-1:0] nxmag, nymag;
    } st7_t;

    typedef struct packed {
        coords_t c;
        logic            valid;
        logic            qxneg, qyneg;
        logic [N2W-1:0]  num2x, num2y;
        logic [DENW-1:0] den2;
    } st8_t;

    typedef struct packed {
        coords_t c;
        logic            valid;
        logic            qxneg, qyneg;
        logic            ovfx, ovfy;
        logic [N2W-1:0]  rx, ry;
        logic [DENW-1:0] den2;
        logic [QW-1:0]   qx, qy;
    } div_t;

    typedef struct packed {
        coords_t c;
        logic                 valid;
        logic signed [CW-1:0] ox, oy;
    } st9_t;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] ox, oy;
        logic signed [DW-1:0] dax, day, dbx, dby, dcx, dcy, dpx, dpy;
    } st10_t;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] ox, oy;
        logic [SQW-1:0]       sax, say, sbx, sby, scx, scy, spx, spy;
    } st11_t;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] ox, oy;
        logic [SW-1:0]        da, db, dc, dq;
    } st12_t;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] ox, oy;
        logic [SW-1:0]        r1, dc, dq;
    } st13_t;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] ox, oy;
        logic [SW-1:0]        rmin, dq;
    } st14_t;

    // square of a difference; always fits the unsigned square width
    function automatic logic [SQW-1:0] sq_diff(input logic signed [DW-1:0] v);
        logic signed [2*DW-1:0] p;
        p = v * v;
        return p[SQW-1:0];
    endfunction

    // signed difference times low slice of an unsigned sum of squares
    function automatic logic signed [LPW-1:0] mul_lo(input logic signed [DW-1:0] a,
                                                     input logic [LO_W-1:0] b);
        logic signed [LO_W:0] bs;
        bs = signed'({1'b0, b});
        return a * bs;
    endfunction

    // signed difference times high slice of an unsigned sum of squares
    function automatic logic signed [HPW-1:0] mul_hi(input logic signed [DW-1:0] a,
                                                     input logic [HI_W-1:0] b);
        logic signed [HI_W:0] bs;
        bs = signed'({1'b0, b});
        return a * bs;
    endfunction

    // vertex A plus signed rounded offset, clamped to the signed 32-bit range
    function automatic logic signed [CW-1:0] sat_center(input logic signed [CW-1:0] a,
                                                        input logic [QW-1:0] q,
                                                        input logic neg,
                                                        input logic ovf);
        logic signed [SUMW-1:0] qs;
        logic signed [SUMW-1:0] u;
        logic signed [CW-1:0]   r;
        qs = signed'(SUMW'(q));
        if (neg)
        begin
            qs = -qs;
        end
        u = SUMW'(a) + qs;
        if (ovf)
        begin
            r = neg ? S32_MIN : S32_MAX;
        end
        else if (u > SUMW'(S32_MAX))
        begin
            r = S32_MAX;
        end
        else if (u < SUMW'(S32_MIN))
        begin
            r = S32_MIN;
        end
        else
        begin
            r = u[CW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/triangle_circumcircle_incircle.sv =====
// ============================================================================
// triangle_circumcircle_incircle
// Pipelined circumcircle and in-circle test for one triangle and one point.
// ============================================================================
// Usage:
//   s_* channel: one word per test, three vertices and a query point,
//   each signed Q16.16. m_* channel: circumcenter, squared radius (Q32.32,
//   saturated, all ones when infinite) and the in-circle flag in tdata, the
//   triangle-valid flag in tuser. cfg_we/cfg_wdata write the area threshold
//   (Q0.32); write it only while no word is in flight.
//   Throughput: one word per cycle while the skid register is free. The
//   rounded center division is a chain of registered steps, one overflow
//   check and then one restoring step per quotient bit; the other stages
//   are multiply, add and compare stages plus the output register.
//   Reset clears all valid bits and sets the threshold to 1.
//   When the receiver stalls, the output register holds its word and one
//   more word lands in a skid register; only then does s_tready drop and
//   the whole pipeline freezes, losing nothing.
// ============================================================================
`include "assert_macros.svh"

module triangle_circumcircle_incircle
(
    input  logic                          clk,
    input  logic                          rst_n,
    // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, query_x, query_y
    input  logic [tcci_pkg::IN_W-1:0]     s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // center_x, center_y, radius_sq, inside_res, zero pad
    output logic [tcci_pkg::OUT_DW-1:0]   m_tdata,
    // tri_valid
    output logic [tcci_pkg::OUT_UW-1:0]   m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_we,
    input  logic [tcci_pkg::CW-1:0]       cfg_wdata
);
    import tcci_pkg::*;

    localparam int NST = 8 + (QW + 1) + 7;

    logic [CW-1:0]  thr_reg;
    logic [NST-1:0] vld_reg, vld_next;
    logic           en;

    coords_t in_c;
    st1_t    st1_reg,  st1_next;
    st2_t    st2_reg,  st2_next;
    st3_t    st3_reg,  st3_next;
    st4_t    st4_reg,  st4_next;
    st5_t    st5_reg,  st5_next;
    st6_t    st6_reg,  st6_next;
    st7_t    st7_reg,  st7_next;
    st8_t    st8_reg,  st8_next;
    div_t    dv_reg [0:QW];
    div_t    dv_next[0:QW];
    st9_t    st9_reg,  st9_next;
    st10_t   st10_reg, st10_next;
    st11_t   st11_reg, st11_next;
    st12_t   st12_reg, st12_next;
    st13_t   st13_reg, st13_next;
    st14_t   st14_reg, st14_next;
    result_t st15_reg, st15_next;

    result_t out_reg, out_next, skid_reg, skid_next;
    logic    out_v_reg, out_v_next, skid_v_reg, skid_v_next;
    logic    push;

    // pipeline advances while the skid register is free
    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign push     = en && vld_reg[NST-1];
    assign vld_next = {vld_reg[NST-2:0], s_tvalid};

    // unpack input word, first field lowest
    always_comb
    begin
        in_c.ax = s_tdata[0*CW +: CW];
        in_c.ay = s_tdata[1*CW +: CW];
        in_c.bx = s_tdata[2*CW +: CW];
        in_c.by = s_tdata[3*CW +: CW];
        in_c.cx = s_tdata[4*CW +: CW];
        in_c.cy = s_tdata[5*CW +: CW];
        in_c.px = s_tdata[6*CW +: CW];
        in_c.py = s_tdata[7*CW +: CW];
    end

    // stage 1: edges relative to A
    always_comb
    begin
        st1_next.c   = in_c;
        st1_next.bxp = DW'(in_c.bx) - DW'(in_c.ax);
        st1_next.byp = DW'(in_c.by) - DW'(in_c.ay);
        st1_next.cxp = DW'(in_c.cx) - DW'(in_c.ax);
        st1_next.cyp = DW'(in_c.cy) - DW'(in_c.ay);
    end

    // stage 2: cross terms and squares
    always_comb
    begin
        st2_next.c   = st1_reg.c;
        st2_next.bxp = st1_reg.bxp;
        st2_next.byp = st1_reg.byp;
        st2_next.cxp = st1_reg.cxp;
        st2_next.cyp = st1_reg.cyp;
        st2_next.k1  = st1_reg.bxp * st1_reg.cyp;
        st2_next.k2  = st1_reg.byp * st1_reg.cxp;
        st2_next.bb  = sq_diff(st1_reg.bxp);
        st2_next.byy = sq_diff(st1_reg.byp);
        st2_next.cxx = sq_diff(st1_reg.cxp);
        st2_next.cyy = sq_diff(st1_reg.cyp);
    end

    // stage 3: cross product K and edge lengths squared
    always_comb
    begin
        st3_next.c   = st2_reg.c;
        st3_next.bxp = st2_reg.bxp;
        st3_next.byp = st2_reg.byp;
        st3_next.cxp = st2_reg.cxp;
        st3_next.cyp = st2_reg.cyp;
        st3_next.k   = KW'(st2_reg.k1) - KW'(st2_reg.k2);
        st3_next.sb  = SW'(st2_reg.bb) + SW'(st2_reg.byy);
        st3_next.sc  = SW'(st2_reg.cxx) + SW'(st2_reg.cyy);
    end

    // stage 4: |K| and numerator partial products
    always_comb
    begin
        logic signed [KW-1:0] kabs;
        kabs = st3_reg.k[KW-1] ? -st3_reg.k : st3_reg.k;
        st4_next.c     = st3_reg.c;
        st4_next.ksign = st3_reg.k[KW-1];
        st4_next.kmag  = kabs[KMW-1:0];
        st4_next.pyl   = mul_lo(st3_reg.cyp, st3_reg.sb[LO_W-1:0]);
        st4_next.pyh   = mul_hi(st3_reg.cyp, st3_reg.sb[SW-1:LO_W]);
        st4_next.pbl   = mul_lo(st3_reg.byp, st3_reg.sc[LO_W-1:0]);
        st4_next.pbh   = mul_hi(st3_reg.byp, st3_reg.sc[SW-1:LO_W]);
        st4_next.pxl   = mul_lo(st3_reg.bxp, st3_reg.sc[LO_W-1:0]);
        st4_next.pxh   = mul_hi(st3_reg.bxp, st3_reg.sc[SW-1:LO_W]);
        st4_next.pcl   = mul_lo(st3_reg.cxp, st3_reg.sb[LO_W-1:0]);
        st4_next.pch   = mul_hi(st3_reg.cxp, st3_reg.sb[SW-1:LO_W]);
    end

    // stage 5: merge partial products, area test
    always_comb
    begin
        st5_next.c     = st4_reg.c;
        st5_next.ksign = st4_reg.ksign;
        st5_next.kmag  = st4_reg.kmag;
        st5_next.valid = st4_reg.kmag > KMW'({thr_reg, 1'b0});
        st5_next.tcy   = (NW'(st4_reg.pyh) <<< LO_W) + NW'(st4_reg.pyl);
        st5_next.tby   = (NW'(st4_reg.pbh) <<< LO_W) + NW'(st4_reg.pbl);
        st5_next.tbx   = (NW'(st4_reg.pxh) <<< LO_W) + NW'(st4_reg.pxl);
        st5_next.tcx   = (NW'(st4_reg.pch) <<< LO_W) + NW'(st4_reg.pcl);
    end

    // stage 6: determinant numerators
    always_comb
    begin
        st6_next.c     = st5_reg.c;
        st6_next.ksign = st5_reg.ksign;
        st6_next.kmag  = st5_reg.kmag;
        st6_next.valid = st5_reg.valid;
        st6_next.nx    = st5_reg.tcy - st5_reg.tby;
        st6_next.ny    = st5_reg.tbx - st5_reg.tcx;
    end

    // stage 7: numerator magnitudes
    always_comb
    begin
        logic signed [NW-1:0] ax_abs, ay_abs;
        ax_abs = st6_reg.nx[NW-1] ? -st6_reg.nx : st6_reg.nx;
        ay_abs = st6_reg.ny[NW-1] ? -st6_reg.ny : st6_reg.ny;
        st7_next.c     = st6_reg.c;
        st7_next.ksign = st6_reg.ksign;
        st7_next.kmag  = st6_reg.kmag;
        st7_next.valid = st6_reg.valid;
        st7_next.nxneg = st6_reg.nx[NW-1];
        st7_next.nyneg = st6_reg.ny[NW-1];
        st7_next.nxmag = ax_abs[NMW-1:0];
        st7_next.nymag = ay_abs[NMW-1:0];
    end

    // stage 8: round-half-away operands, (2|N| + 2|K|) / 4|K|
    always_comb
    begin
        st8_next.c     = st7_reg.c;
        st8_next.valid = st7_reg.valid;
        st8_next.qxneg = st7_reg.nxneg ^ st7_reg.ksign;
        st8_next.qyneg = st7_reg.nyneg ^ st7_reg.ksign;
        st8_next.num2x = (N2W'(st7_reg.nxmag) << 1) + N2W'({st7_reg.kmag, 1'b0});
        st8_next.num2y = (N2W'(st7_reg.nymag) << 1) + N2W'({st7_reg.kmag, 1'b0});
        st8_next.den2  = {st7_reg.kmag, 2'b00};
    end

    // divider: overflow check, then one restoring step per quotient bit
    always_comb
    begin
        logic [RW-1:0] shd, rxw, ryw;
        dv_next[0].c     = st8_reg.c;
        dv_next[0].valid = st8_reg.valid;
        dv_next[0].qxneg = st8_reg.qxneg;
        dv_next[0].qyneg = st8_reg.qyneg;
        dv_next[0].ovfx  = RW'(st8_reg.num2x) >= (RW'(st8_reg.den2) << QW);
        dv_next[0].ovfy  = RW'(st8_reg.num2y) >= (RW'(st8_reg.den2) << QW);
        dv_next[0].rx    = st8_reg.num2x;
        dv_next[0].ry    = st8_reg.num2y;
        dv_next[0].den2  = st8_reg.den2;
        dv_next[0].qx    = '0;
        dv_next[0].qy    = '0;
        for (int j = 1; j <= QW; j++)
        begin
            dv_next[j] = dv_reg[j-1];
            shd = RW'(dv_reg[j-1].den2) << (QW - j);
            rxw = RW'(dv_reg[j-1].rx);
            ryw = RW'(dv_reg[j-1].ry);
            if (rxw >= shd)
            begin
                rxw = rxw - shd;
                dv_next[j].qx[QW-j] = 1'b1;
            end
            if (ryw >= shd)
            begin
                ryw = ryw - shd;
                dv_next[j].qy[QW-j] = 1'b1;
            end
            dv_next[j].rx = rxw[N2W-1:0];
            dv_next[j].ry = ryw[N2W-1:0];
        end
    end

    // stage 9: saturated circumcenter
    always_comb
    begin
        st9_next.c     = dv_reg[QW].c;
        st9_next.valid = dv_reg[QW].valid;
        st9_next.ox    = sat_center(dv_reg[QW].c.ax, dv_reg[QW].qx,
                                    dv_reg[QW].qxneg, dv_reg[QW].ovfx);
        st9_next.oy    = sat_center(dv_reg[QW].c.ay, dv_reg[QW].qy,
                                    dv_reg[QW].qyneg, dv_reg[QW].ovfy);
    end

    // stage 10: offsets of vertices and query from the center
    always_comb
    begin
        st10_next.valid = st9_reg.valid;
        st10_next.ox    = st9_reg.ox;
        st10_next.oy    = st9_reg.oy;
        st10_next.dax   = DW'(st9_reg.c.ax) - DW'(st9_reg.ox);
        st10_next.day   = DW'(st9_reg.c.ay) - DW'(st9_reg.oy);
        st10_next.dbx   = DW'(st9_reg.c.bx) - DW'(st9_reg.ox);
        st10_next.dby   = DW'(st9_reg.c.by) - DW'(st9_reg.oy);
        st10_next.dcx   = DW'(st9_reg.c.cx) - DW'(st9_reg.ox);
        st10_next.dcy   = DW'(st9_reg.c.cy) - DW'(st9_reg.oy);
        st10_next.dpx   = DW'(st9_reg.c.px) - DW'(st9_reg.ox);
        st10_next.dpy   = DW'(st9_reg.c.py) - DW'(st9_reg.oy);
    end

    // stage 11: squares
    always_comb
    begin
        st11_next.valid = st10_reg.valid;
        st11_next.ox    = st10_reg.ox;
        st11_next.oy    = st10_reg.oy;
        st11_next.sax   = sq_diff(st10_reg.dax);
        st11_next.say   = sq_diff(st10_reg.day);
        st11_next.sbx   = sq_diff(st10_reg.dbx);
        st11_next.sby   = sq_diff(st10_reg.dby);
        st11_next.scx   = sq_diff(st10_reg.dcx);
        st11_next.scy   = sq_diff(st10_reg.dcy);
        st11_next.spx   = sq_diff(st10_reg.dpx);
        st11_next.spy   = sq_diff(st10_reg.dpy);
    end

    // stage 12: squared distances
    always_comb
    begin
        st12_next.valid = st11_reg.valid;
        st12_next.ox    = st11_reg.ox;
        st12_next.oy    = st11_reg.oy;
        st12_next.da    = SW'(st11_reg.sax) + SW'(st11_reg.say);
        st12_next.db    = SW'(st11_reg.sbx) + SW'(st11_reg.sby);
        st12_next.dc    = SW'(st11_reg.scx) + SW'(st11_reg.scy);
        st12_next.dq    = SW'(st11_reg.spx) + SW'(st11_reg.spy);
    end

    // stage 13: min of A and B
    always_comb
    begin
        st13_next.valid = st12_reg.valid;
        st13_next.ox    = st12_reg.ox;
        st13_next.oy    = st12_reg.oy;
        st13_next.r1    = (st12_reg.db < st12_reg.da) ? st12_reg.db : st12_reg.da;
        st13_next.dc    = st12_reg.dc;
        st13_next.dq    = st12_reg.dq;
    end

    // stage 14: min with C
    always_comb
    begin
        st14_next.valid = st13_reg.valid;
        st14_next.ox    = st13_reg.ox;
        st14_next.oy    = st13_reg.oy;
        st14_next.rmin  = (st13_reg.dc < st13_reg.r1) ? st13_reg.dc : st13_reg.r1;
        st14_next.dq    = st13_reg.dq;
    end

    // stage 15: in-circle test, saturation, degenerate override
    always_comb
    begin
        if (st14_reg.valid)
        begin
            st15_next.center_x   = st14_reg.ox;
            st15_next.center_y   = st14_reg.oy;
            st15_next.radius_sq  = st14_reg.rmin[SW-1] ? '1 : st14_reg.rmin[RSQW-1:0];
            st15_next.tri_valid  = 1'b1;
            st15_next.inside_res = st14_reg.dq < st14_reg.rmin;
        end
        else
        begin
            st15_next.center_x   = '0;
            st15_next.center_y   = '0;
            st15_next.radius_sq  = '1;
            st15_next.tri_valid  = 1'b0;
            st15_next.inside_res = 1'b1;
        end
    end

    // pipeline payload, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_reg  <= st1_next;
            st2_reg  <= st2_next;
            st3_reg  <= st3_next;
            st4_reg  <= st4_next;
            st5_reg  <= st5_next;
            st6_reg  <= st6_next;
            st7_reg  <= st7_next;
            st8_reg  <= st8_next;
            dv_reg   <= dv_next;
            st9_reg  <= st9_next;
            st10_reg <= st10_next;
            st11_reg <= st11_next;
            st12_reg <= st12_next;
            st13_reg <= st13_next;
            st14_reg <= st14_next;
            st15_reg <= st15_next;
        end
    end

    // output register and skid register
    always_comb
    begin
        out_next    = out_reg;
        out_v_next  = out_v_reg;
        skid_next   = skid_reg;
        skid_v_next = skid_v_reg;
        if (!out_v_reg || m_tready)
        begin
            if (skid_v_reg)
            begin
                out_next    = skid_reg;
                out_v_next  = 1'b1;
                skid_v_next = 1'b0;
            end
            else
            begin
                out_next   = st15_reg;
                out_v_next = push;
            end
        end
        else if (push)
        begin
            skid_next   = st15_reg;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THR_RESET;
            vld_reg    <= '0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (en)
            begin
                vld_reg <= vld_next;
            end
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    assign m_tvalid   = out_v_reg;
    assign m_tdata    = {{OUT_PAD{1'b0}}, out_reg.inside_res, out_reg.radius_sq,
                         out_reg.center_y, out_reg.center_x};
    assign m_tuser[0] = out_reg.tri_valid;

    // checks
    `ASSERT_IMPLIES(a_skid_needs_out, skid_v_reg, out_v_reg)
    `ASSERT_NEXT(a_skid_fill, out_v_reg && !m_tready && push, skid_v_reg)
    `ASSERT_NEXT(a_skid_drain, skid_v_reg && m_tready, !skid_v_reg && out_v_reg)
    `ASSERT_IMPLIES(a_degenerate_word, out_v_reg && !out_reg.tri_valid,
                    out_reg.inside_res && (&out_reg.radius_sq) && out_reg.center_x == '0)

endmodule

// ===== tb/triangle_circumcircle_incircle_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// triangle_circumcircle_incircle_tb
// Self-checking bench for the circumcircle / in-circle block. A directed
// table of triangles comes first: degenerate, tiny, extreme and exact-edge
// cases. Random triangles follow under several area thresholds. Every
// accepted word is checked field by field against its table entry or a
// wide exact integer prediction. Both sides idle at random but in one steady phase.
// ============================================================================
module triangle_circumcircle_incircle_tb;

    import tcci_pkg::*;

    localparam int    WW        = 200;      // exact arithmetic width
    localparam int    LATENCY   = 52;
    localparam int    DOG_LIMIT = 5000;
    localparam int    N_PHASE   = 5;
    localparam int    PHASE_LEN = 200;
    localparam real   HALF_HI   = 6.0;
    localparam real   HALF_LO   = 6.0;

    typedef logic signed [WW-1:0] wide_t;

    typedef struct {
        coords_t c;
        bit      known;
        result_t res;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic [IN_W-1:0]     s_tdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [OUT_DW-1:0]   m_tdata;
    logic [OUT_UW-1:0]   m_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic                cfg_we;
    logic [CW-1:0]       cfg_wdata;

    logic [CW-1:0]       area_thr;
    result_t             expected_results[$];
    row_t                dir_rows[$];
    int                  err_count;
    int                  idle_cycles;
    bit                  steady;

    triangle_circumcircle_incircle uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #(HALF_HI);
        clk = 1'b0;
        #(HALF_LO);
    end

    // squared distance, exact
    function automatic wide_t dist_sq(input wide_t px, input wide_t py,
                                      input wide_t qx, input wide_t qy);
        wide_t dx;
        wide_t dy;
        dx = px - qx;
        dy = py - qy;
        return dx * dx + dy * dy;
    endfunction

    // offset n / d rounded to nearest, ties away from zero
    function automatic wide_t round_div(input wide_t n, input wide_t d);
        wide_t nm;
        wide_t dm;
        wide_t q;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        q  = (2 * nm + dm) / (2 * dm);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic logic signed [CW-1:0] clamp_s32(input wide_t v);
        wide_t wmax;
        wide_t wmin;
        wmax = S32_MAX;
        wmin = S32_MIN;
        if (v > wmax)
        begin
            return S32_MAX;
        end
        if (v < wmin)
        begin
            return S32_MIN;
        end
        return v[CW-1:0];
    endfunction

    // circumcircle of the triangle and in-circle flag of the query point
    function automatic result_t predict_circle(input coords_t c);
        result_t r;
        wide_t   ax, ay, bx, by, cx, cy, px, py;
        wide_t   bxp, byp, cxp, cyp, k, kmag, thr2;
        wide_t   sb, sc, nx, ny, ox, oy, da, db, dc, dq, rmin;
        ax = c.ax; ay = c.ay; bx = c.bx; by = c.by;
        cx = c.cx; cy = c.cy; px = c.px; py = c.py;
        bxp = bx - ax; byp = by - ay;
        cxp = cx - ax; cyp = cy - ay;
        k    = bxp * cyp - byp * cxp;
        kmag = (k < 0) ? -k : k;
        thr2 = '0;
        thr2[CW:0] = {area_thr, 1'b0};
        // degenerate or too small: infinite circle
        if (kmag <= thr2)
        begin
            r.center_x   = '0;
            r.center_y   = '0;
            r.radius_sq  = '1;
            r.tri_valid  = 1'b0;
            r.inside_res = 1'b1;
            return r;
        end
        sb = bxp * bxp + byp * byp;
        sc = cxp * cxp + cyp * cyp;
        nx = cyp * sb - byp * sc;
        ny = bxp * sc - cxp * sb;
        r.center_x = clamp_s32(ax + round_div(nx, 2 * k));
        r.center_y = clamp_s32(ay + round_div(ny, 2 * k));
        ox = r.center_x;
        oy = r.center_y;
        da = dist_sq(ax, ay, ox, oy);
        db = dist_sq(bx, by, ox, oy);
        dc = dist_sq(cx, cy, ox, oy);
        dq = dist_sq(px, py, ox, oy);
        rmin = da;
        if (db < rmin)
        begin
            rmin = db;
        end
        if (dc < rmin)
        begin
            rmin = dc;
        end
        r.radius_sq  = (rmin[WW-1:RSQW] != '0) ? '1 : rmin[RSQW-1:0];
        r.tri_valid  = 1'b1;
        r.inside_res = (dq < rmin);
        return r;
    endfunction

    function automatic coords_t make_tri(input int ax, input int ay, input int bx,
                                         input int by, input int cx, input int cy,
                                         input int px, input int py);
        coords_t c;
        c.ax = ax; c.ay = ay; c.bx = bx; c.by = by;
        c.cx = cx; c.cy = cy; c.px = px; c.py = py;
        return c;
    endfunction

    function automatic logic signed [CW-1:0] edge_val();
        case ($urandom_range(5))
            0: return S32_MIN;
            1: return S32_MAX;
            2: return '0;
            3: return -1;
            4: return 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] near(input logic signed [CW-1:0] v,
                                                  input int span);
        return v + $signed($urandom_range(2 * span)) - span;
    endfunction

    // random triangle and query point, several flavors
    function automatic coords_t rand_tri();
        coords_t c;
        int      base_x;
        int      base_y;
        int      t;
        base_x = $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
        base_y = $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
        case ($urandom_range(9))
            0, 1, 2:
            begin
                c = make_tri($urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
            end
            3, 4, 5:
            begin
                c.ax = near(base_x, 1 << 20); c.ay = near(base_y, 1 << 20);
                c.bx = near(base_x, 1 << 20); c.by = near(base_y, 1 << 20);
                c.cx = near(base_x, 1 << 20); c.cy = near(base_y, 1 << 20);
                c.px = near(base_x, 1 << 20); c.py = near(base_y, 1 << 20);
            end
            6:
            begin
                // collinear, C on the line through A and B
                t    = $urandom_range(6) - 3;
                c.ax = near(base_x, 1 << 16); c.ay = near(base_y, 1 << 16);
                c.bx = near(c.ax, 1 << 12);   c.by = near(c.ay, 1 << 12);
                c.cx = c.ax + t * (c.bx - c.ax);
                c.cy = c.ay + t * (c.by - c.ay);
                c.px = $urandom; c.py = $urandom;
            end
            7:
            begin
                // tiny areas around the threshold
                c.ax = $urandom; c.ay = $urandom;
                c.bx = near(c.ax, 3); c.by = near(c.ay, 3);
                c.cx = near(c.ax, 3); c.cy = near(c.ay, 3);
                c.px = near(c.ax, 3); c.py = near(c.ay, 3);
            end
            8:
            begin
                c.ax = near(base_x, 1 << 18); c.ay = near(base_y, 1 << 18);
                c.bx = near(base_x, 1 << 18); c.by = near(base_y, 1 << 18);
                c.cx = near(base_x, 1 << 18); c.cy = near(base_y, 1 << 18);
                c.px = near(c.bx, 2);         c.py = near(c.by, 2);
            end
            default:
            begin
                c = make_tri(edge_val(), edge_val(), edge_val(), edge_val(),
                             edge_val(), edge_val(), edge_val(), edge_val());
            end
        endcase
        return c;
    endfunction

    // send one word; expectation taken from the row or from the predictor
    task automatic send_word(input coords_t c, input bit known, input result_t res);
        while (!steady && $urandom_range(99) < 7)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = {c.py, c.px, c.cy, c.cx, c.by, c.bx, c.ay, c.ax};
        s_tvalid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        expected_results.push_back(known ? res : predict_circle(c));
        @(negedge clk);
    endtask

    // wait until all results are back, then let the pipeline drain
    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    task automatic write_thr(input logic [CW-1:0] v);
        cfg_wdata = v;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        area_thr  = v;
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 7);
    end

    // output checking
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected word %h user %b", $time, m_tdata, m_tuser);
                err_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_tdata[31:0] !== e.center_x)
                begin
                    $display("%0t: center_x exp %h got %h", $time, e.center_x,
                             m_tdata[31:0]);
                    err_count++;
                end
                if (m_tdata[63:32] !== e.center_y)
                begin
                    $display("%0t: center_y exp %h got %h", $time, e.center_y,
                             m_tdata[63:32]);
                    err_count++;
                end
                if (m_tdata[127:64] !== e.radius_sq)
                begin
                    $display("%0t: radius_sq exp %h got %h", $time, e.radius_sq,
                             m_tdata[127:64]);
                    err_count++;
                end
                if (m_tdata[128] !== e.inside_res)
                begin
                    $display("%0t: inside_res exp %b got %b", $time, e.inside_res,
                             m_tdata[128]);
                    err_count++;
                end
                if (m_tuser[0] !== e.tri_valid)
                begin
                    $display("%0t: tri_valid exp %b got %b", $time, e.tri_valid,
                             m_tuser[0]);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= DOG_LIMIT)
        begin
            $display("triangle_circumcircle_incircle_tb: errors");
            $finish;
        end
    end

    initial
    begin
        result_t bad_tri;
        result_t none;
        logic [CW-1:0] thr_list[N_PHASE];
        int q1;
        err_count   = 0;
        idle_cycles = 0;
        steady      = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        area_thr    = THR_RESET;

        bad_tri = '{center_x: '0, center_y: '0, radius_sq: '1,
                    tri_valid: 1'b0, inside_res: 1'b1};
        none    = '0;
        q1      = 1 << 16;

        // directed table
        dir_rows.push_back('{make_tri(0, 0, 0, 0, 0, 0, 0, 0), 1, bad_tri});
        dir_rows.push_back('{make_tri(0, 0, q1, q1, 2 * q1, 2 * q1, 5, 7), 1, bad_tri});
        dir_rows.push_back('{make_tri(0, 0, 1, 0, 0, 1, 0, 0), 1, bad_tri});
        dir_rows.push_back('{make_tri(0, 0, 2, 0, 0, 2, 1, 1), 0, none});
        dir_rows.push_back('{make_tri(0, 0, 2 * q1, 0, 0, 2 * q1, q1, q1), 0, none});
        dir_rows.push_back('{make_tri(0, 0, 2 * q1, 0, 0, 2 * q1, 0, 0), 0, none});
        dir_rows.push_back('{make_tri(0, 0, 0, 2 * q1, 2 * q1, 0, 3 * q1, 3 * q1), 0,
                             none});
        dir_rows.push_back('{make_tri(S32_MIN, S32_MIN, S32_MAX, S32_MIN, S32_MIN,
                                      S32_MAX, S32_MAX, S32_MAX), 0, none});
        dir_rows.push_back('{make_tri(S32_MAX, S32_MAX, S32_MIN, S32_MAX, S32_MAX,
                                      S32_MIN, S32_MIN, S32_MIN), 0, none});
        dir_rows.push_back('{make_tri(S32_MIN, 0, S32_MAX, 0, 0, 1, 0, 0), 0, none});
        dir_rows.push_back('{make_tri(S32_MIN, 0, S32_MAX, 0, 0, -1, 0, 0), 0, none});
        dir_rows.push_back('{make_tri(0, 0, 3, 0, 1, 3, 1, 1), 0, none});
        dir_rows.push_back('{make_tri(-5, -7, 4, 1, -2, 6, S32_MIN, S32_MAX), 0, none});
        dir_rows.push_back('{make_tri(-1, -1, -1, 0, 0, -1, -1, -1), 0, none});
        dir_rows.push_back('{make_tri(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MIN,
                                      S32_MIN, 0, 0), 1, bad_tri});

        thr_list[0] = THR_RESET;
        thr_list[1] = '0;
        thr_list[2] = '1;
        thr_list[3] = $urandom;
        thr_list[4] = $urandom_range(255);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i].c, dir_rows[i].known, dir_rows[i].res);
        end

        for (int ph = 0; ph < N_PHASE; ph++)
        begin
            if (ph != 0)
            begin
                drain();
                write_thr(thr_list[ph]);
            end
            steady = (ph == 2);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                // sender holds off once mid-phase until everything is back
                if (ph == 3 && n == PHASE_LEN / 2)
                begin
                    s_tvalid = 1'b0;
                    while (expected_results.size() != 0)
                    begin
                        @(negedge clk);
                    end
                end
                send_word(rand_tri(), 1'b0, none);
            end
        end
        steady = 1'b0;
        drain();

        if (err_count == 0)
        begin
            $display("triangle_circumcircle_incircle_tb: clean");
        end
        else
        begin
            $display("triangle_circumcircle_incircle_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tcci_pkg.sv
sv/triangle_circumcircle_incircle.sv
tb/triangle_circumcircle_incircle_tb.sv
